@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the bracket nesting checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define BNC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BNC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bnc_pkg.sv @@
// ----------------------------------------------------------------------------
// bnc_pkg
// Types, constants and character decode for the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  // Default stack depth
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned COMPL_W = 64;
  localparam int unsigned BASE_W  = 4;
  localparam int unsigned CFG_A_W = 3;

  // Register reset values
  localparam logic [SCORE_W-1:0] ROUND_RST  = 16'd3;
  localparam logic [SCORE_W-1:0] SQUARE_RST = 16'd57;
  localparam logic [SCORE_W-1:0] CURLY_RST  = 16'd1197;
  localparam logic [SCORE_W-1:0] ANGLE_RST  = 16'd25137;
  localparam logic [BASE_W-1:0]  BASE_RST   = 4'd5;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_ROUND  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_SQUARE = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_CURLY  = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_ANGLE  = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_BASE   = 3'd4;

  // Bracket kinds
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

  // Bracket characters
  localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

  // Line status codes
  typedef enum logic [1:0] {
    LS_BALANCED   = 2'd0,
    LS_INCOMPLETE = 2'd1,
    LS_CORRUPTED  = 2'd2,
    LS_OVERFLOW   = 2'd3
  } line_status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REFILL = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  // Decoded bracket
  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_t;

  function automatic kind_t opener_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    k.hit  = 1'b1;
    k.kind = KIND_ROUND;
    case (c)
      CH_OPEN_ROUND:  k.kind = KIND_ROUND;
      CH_OPEN_SQUARE: k.kind = KIND_SQUARE;
      CH_OPEN_CURLY:  k.kind = KIND_CURLY;
      CH_OPEN_ANGLE:  k.kind = KIND_ANGLE;
      default:        k.hit  = 1'b0;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    k.hit  = 1'b1;
    k.kind = KIND_ROUND;
    case (c)
      CH_CLOSE_ROUND:  k.kind = KIND_ROUND;
      CH_CLOSE_SQUARE: k.kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  k.kind = KIND_CURLY;
      CH_CLOSE_ANGLE:  k.kind = KIND_ANGLE;
      default:         k.hit  = 1'b0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/bnc_ram.sv @@
// ----------------------------------------------------------------------------
// bnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bnc_compl.sv @@
// ----------------------------------------------------------------------------
// bnc_compl
// Completion score accumulator: score = score * base + kind + 1, saturating.
// ----------------------------------------------------------------------------
module bnc_compl (
  input  logic                         clk,
  input  logic                         clear,
  input  logic                         step,
  input  logic [bnc_pkg::BASE_W-1:0]   base,
  input  logic [bnc_pkg::KIND_W-1:0]   kind,
  output logic [bnc_pkg::COMPL_W-1:0]  score
);

  localparam int unsigned PROD_W = bnc_pkg::COMPL_W + bnc_pkg::BASE_W;

  logic [bnc_pkg::COMPL_W-1:0] score_r;
  logic [bnc_pkg::COMPL_W-1:0] score_nxt;
  logic [PROD_W-1:0]           prod;
  logic [PROD_W:0]             sum;

  // Multiply-add one stack entry, clamp to all ones on overflow
  always_comb begin
    prod      = PROD_W'(score_r) * PROD_W'(base);
    sum       = (PROD_W+1)'(prod) + (PROD_W+1)'(kind) + (PROD_W+1)'(1);
    score_nxt = score_r;
    if (clear) begin
      score_nxt = '0;
    end else if (step) begin
      if (sum[PROD_W:bnc_pkg::COMPL_W] != '0) begin
        score_nxt = '1;
      end else begin
        score_nxt = sum[bnc_pkg::COMPL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
  end

  assign score = score_r;

endmodule

@@ rtl/bracket_nesting_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_nesting_checker
// Checks bracket nesting per line and reports corruption and completion scores.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per beat in in_tdata[7:0], in_tlast marks the last
//           character of a line.
//   out_* : one beat per line. out_tuser[1:0] is the line status, out_tdata
//           holds illegal score, running corruption total, completion score.
//   cfg_* : register writes (index in cfg_addr, value in cfg_data), always
//           ready; write only while the block is idle.
// Sequencing:
//   An ordinary character or a push is taken in the idle state. A matched
//   closer that leaves the stack non-empty passes through a refill state: the
//   stack RAM's registered read refills the cached top entry; one that empties
//   the stack does not. A line end goes straight to the emit state when no walk
//   is needed; for an incomplete line the completion walk first reads the stack
//   RAM one entry per cycle, top down, into the multiply-add unit. The result
//   beat becomes valid in the same cycle that the input is ready again.
// Reset clears the line state, the running total and the registers to their
// defaults; the stack RAM is not cleared. A stalled receiver holds the result
// beat; the next line end waits until that beat is taken, while characters
// inside a line continue to be accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_nesting_checker #(
  parameter int unsigned STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [7:0] in_char
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tlast,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: [15:0] illegal_score, [63:16] corruption_total,
  //            [127:64] completion_score
  output logic [127:0]                  out_tdata,
  // out_tuser: [1:0] line_status
  output logic [1:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bnc_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [bnc_pkg::SCORE_W-1:0]   cfg_data
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Configuration registers
  logic [bnc_pkg::SCORE_W-1:0] round_r, square_r, curly_r, angle_r;
  logic [bnc_pkg::BASE_W-1:0]  base_r;

  // Line state
  bnc_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [bnc_pkg::KIND_W-1:0]  top_r, top_nxt;
  logic                        corr_r, corr_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [bnc_pkg::SCORE_W-1:0] first_r, first_nxt;
  logic [bnc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [CW-1:0]               walk_r, walk_nxt;
  logic                        pend_r, pend_nxt;

  // Result beat
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;
  logic [bnc_pkg::SCORE_W-1:0] out_illegal_r, out_illegal_nxt;
  logic [bnc_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [bnc_pkg::COMPL_W-1:0] out_compl_r, out_compl_nxt;

  // Stack RAM and completion unit hookup
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [bnc_pkg::KIND_W-1:0]  ram_wdata, ram_rdata;
  logic                        compl_clear, compl_step;
  logic [bnc_pkg::COMPL_W-1:0] compl_score;

  bnc_pkg::kind_t              op_k, cl_k;
  logic                        in_fire, out_free, popped;
  logic [CW-1:0]               cnt_v;
  logic                        corr_v, ovf_v;
  logic [bnc_pkg::TOTAL_W:0]   total_sum;
  logic [CW-1:0]               walk_dec, cnt_dec;

  assign in_tready = (state_r == bnc_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign op_k      = bnc_pkg::opener_kind(in_tdata);
  assign cl_k      = bnc_pkg::closer_kind(in_tdata);
  assign walk_dec  = walk_r - CW'(1);
  assign total_sum = {1'b0, total_r} + (bnc_pkg::TOTAL_W+1)'(first_r);

  // Score of an illegal closer by kind
  function automatic logic [bnc_pkg::SCORE_W-1:0] closer_score(
    input logic [bnc_pkg::KIND_W-1:0] k,
    input logic [bnc_pkg::SCORE_W-1:0] s0,
    input logic [bnc_pkg::SCORE_W-1:0] s1,
    input logic [bnc_pkg::SCORE_W-1:0] s2,
    input logic [bnc_pkg::SCORE_W-1:0] s3
  );
    logic [bnc_pkg::SCORE_W-1:0] s;
    case (k)
      bnc_pkg::KIND_ROUND:  s = s0;
      bnc_pkg::KIND_SQUARE: s = s1;
      bnc_pkg::KIND_CURLY:  s = s2;
      default:              s = s3;
    endcase
    return s;
  endfunction

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    top_nxt         = top_r;
    corr_nxt        = corr_r;
    ovf_nxt         = ovf_r;
    first_nxt       = first_r;
    total_nxt       = total_r;
    walk_nxt        = walk_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_illegal_nxt = out_illegal_r;
    out_total_nxt   = out_total_r;
    out_compl_nxt   = out_compl_r;
    ram_we          = 1'b0;
    ram_waddr       = count_r[AW-1:0];
    ram_wdata       = op_k.kind;
    ram_raddr       = walk_dec[AW-1:0];
    compl_clear     = 1'b0;
    compl_step      = 1'b0;
    popped          = 1'b0;
    cnt_v           = count_r;
    corr_v          = corr_r;
    ovf_v           = ovf_r;
    cnt_dec         = count_r - CW'(1);

    case (state_r)
      bnc_pkg::ST_IDLE: begin
        if (in_fire) begin
          // Push, pop or flag the line
          if (!corr_r && !ovf_r) begin
            if (op_k.hit) begin
              if (count_r < CW'(STACK_DEPTH)) begin
                ram_we  = 1'b1;
                top_nxt = op_k.kind;
                cnt_v   = count_r + CW'(1);
              end else begin
                ovf_v = 1'b1;
              end
            end else if (cl_k.hit) begin
              if (count_r != '0 && top_r == cl_k.kind) begin
                cnt_v  = cnt_dec;
                popped = 1'b1;
              end else begin
                corr_v    = 1'b1;
                first_nxt = closer_score(cl_k.kind, round_r, square_r, curly_r, angle_r);
              end
            end
          end
          count_nxt = cnt_v;
          corr_nxt  = corr_v;
          ovf_nxt   = ovf_v;
          // Line end: walk an incomplete stack, else report at once
          cnt_dec   = cnt_v - CW'(1);
          ram_raddr = cnt_dec[AW-1:0];
          if (in_tlast) begin
            if (!corr_v && !ovf_v && cnt_v != '0) begin
              walk_nxt    = cnt_v;
              pend_nxt    = 1'b0;
              compl_clear = 1'b1;
              state_nxt   = bnc_pkg::ST_WALK;
            end else begin
              state_nxt = bnc_pkg::ST_EMIT;
            end
          end else if (popped && cnt_v != '0) begin
            state_nxt = bnc_pkg::ST_REFILL;
          end
        end
      end

      bnc_pkg::ST_REFILL: begin
        // Load the new top entry after a pop
        top_nxt   = ram_rdata;
        state_nxt = bnc_pkg::ST_IDLE;
      end

      bnc_pkg::ST_WALK: begin
        // Read one entry per cycle, top down, into the multiply-add unit
        compl_step = pend_r;
        if (walk_r != '0) begin
          walk_nxt = walk_dec;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = bnc_pkg::ST_EMIT;
          end
        end
      end

      bnc_pkg::ST_EMIT: begin
        // Hand the result to the output register and clear the line
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_illegal_nxt = '0;
          out_compl_nxt   = '0;
          out_total_nxt   = total_r;
          if (corr_r) begin
            out_status_nxt  = bnc_pkg::LS_CORRUPTED;
            out_illegal_nxt = first_r;
            if (total_sum[bnc_pkg::TOTAL_W]) begin
              total_nxt = '1;
            end else begin
              total_nxt = total_sum[bnc_pkg::TOTAL_W-1:0];
            end
            out_total_nxt = total_nxt;
          end else if (ovf_r) begin
            out_status_nxt = bnc_pkg::LS_OVERFLOW;
          end else if (count_r == '0) begin
            out_status_nxt = bnc_pkg::LS_BALANCED;
          end else begin
            out_status_nxt = bnc_pkg::LS_INCOMPLETE;
            out_compl_nxt  = compl_score;
          end
          count_nxt = '0;
          corr_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          first_nxt = '0;
          state_nxt = bnc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bnc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bnc_pkg::ST_IDLE;
      count_r     <= '0;
      corr_r      <= 1'b0;
      ovf_r       <= 1'b0;
      first_r     <= '0;
      total_r     <= '0;
      walk_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      corr_r      <= corr_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      total_r     <= total_nxt;
      walk_r      <= walk_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r         <= top_nxt;
    out_status_r  <= out_status_nxt;
    out_illegal_r <= out_illegal_nxt;
    out_total_r   <= out_total_nxt;
    out_compl_r   <= out_compl_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r  <= bnc_pkg::ROUND_RST;
      square_r <= bnc_pkg::SQUARE_RST;
      curly_r  <= bnc_pkg::CURLY_RST;
      angle_r  <= bnc_pkg::ANGLE_RST;
      base_r   <= bnc_pkg::BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        bnc_pkg::REG_ROUND:  round_r  <= cfg_data;
        bnc_pkg::REG_SQUARE: square_r <= cfg_data;
        bnc_pkg::REG_CURLY:  curly_r  <= cfg_data;
        bnc_pkg::REG_ANGLE:  angle_r  <= cfg_data;
        bnc_pkg::REG_BASE:   base_r   <= cfg_data[bnc_pkg::BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bnc_ram #(
    .WIDTH (bnc_pkg::KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bnc_compl u_compl (
    .clk   (clk),
    .clear (compl_clear),
    .step  (compl_step),
    .base  (base_r),
    .kind  (ram_rdata),
    .score (compl_score)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_compl_r, out_total_r, out_illegal_r};

  // Assertions
  `BNC_ASSERT(a_count_bound, clk, rst_n, (count_r <= CW'(STACK_DEPTH)),
              "stack count beyond depth")
  `BNC_ASSERT(a_compl_only_incomplete, clk, rst_n,
              (out_tvalid && out_tuser != bnc_pkg::LS_INCOMPLETE) |-> (out_tdata[127:64] == '0),
              "completion score on a line that is not incomplete")
  `BNC_ASSERT(a_illegal_only_corrupt, clk, rst_n,
              (out_tvalid && out_tuser != bnc_pkg::LS_CORRUPTED) |-> (out_tdata[15:0] == '0),
              "illegal score on a line that is not corrupted")
  `BNC_ASSERT_ALWAYS(a_state_onehot, clk, (!rst_n || $onehot(state_r)),
                     "sequencer state not one-hot")

endmodule

@@ bench/tb_bracket_nesting_checker.sv @@
// ----------------------------------------------------------------------------
// tb_bracket_nesting_checker
// Self-checking bench for the bracket nesting checker. Lines of characters are
// queued up front and streamed in by a clocked driver; a clocked monitor keeps
// its own bracket stack, scores and running total, predicts one report per
// line end and compares every report beat field by field. Register settings
// change between phases while the block is drained, covering the extremes.
// ----------------------------------------------------------------------------
module tb_bracket_nesting_checker;

  localparam int unsigned DEPTH     = bnc_pkg::STACK_DEPTH_DEF;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE    = DEPTH + 16;

  // One character beat, or a marker that holds the sender until drained
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       drain;
  } beat_t;

  typedef struct packed {
    logic       opener;
    logic       closer;
    logic [1:0] kind;
  } char_class_t;

  typedef struct {
    bnc_pkg::line_status_t status;
    logic [15:0]           illegal;
    logic [47:0]           total;
    logic [63:0]           compl;
  } line_report_t;

  typedef enum {LN_BAL, LN_OPEN, LN_BAD, LN_NOISE, LN_DEEP} line_shape_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [bnc_pkg::CFG_A_W-1:0] cfg_addr = '0;
  logic [bnc_pkg::SCORE_W-1:0] cfg_data = '0;

  bracket_nesting_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // Stimulus and expectation stores
  beat_t        line_chars_q[$];
  line_report_t report_q[$];
  int unsigned  fail_cnt = 0;
  int unsigned  idle_pct = 0;

  // Driver and receiver state
  beat_t       tx_beat = '0;
  logic        drv_busy = 1'b0;
  logic        in_taken = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;

  // Predictor state: line stack, line flags, registers
  logic [1:0]  kind_stk [0:DEPTH-1];
  int unsigned stk_cnt = 0;
  logic        ln_bad = 1'b0;
  logic        ln_ovf = 1'b0;
  logic [15:0] ln_score = '0;
  logic [47:0] bad_total = '0;
  logic [15:0] close_score [0:3] = '{bnc_pkg::ROUND_RST, bnc_pkg::SQUARE_RST,
                                     bnc_pkg::CURLY_RST, bnc_pkg::ANGLE_RST};
  logic [3:0]  mult_base = bnc_pkg::BASE_RST;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic char_class_t classify(logic [7:0] c);
    char_class_t r;
    r = '0;
    case (c)
      bnc_pkg::CH_OPEN_ROUND:   r = {1'b1, 1'b0, bnc_pkg::KIND_ROUND};
      bnc_pkg::CH_OPEN_SQUARE:  r = {1'b1, 1'b0, bnc_pkg::KIND_SQUARE};
      bnc_pkg::CH_OPEN_CURLY:   r = {1'b1, 1'b0, bnc_pkg::KIND_CURLY};
      bnc_pkg::CH_OPEN_ANGLE:   r = {1'b1, 1'b0, bnc_pkg::KIND_ANGLE};
      bnc_pkg::CH_CLOSE_ROUND:  r = {1'b0, 1'b1, bnc_pkg::KIND_ROUND};
      bnc_pkg::CH_CLOSE_SQUARE: r = {1'b0, 1'b1, bnc_pkg::KIND_SQUARE};
      bnc_pkg::CH_CLOSE_CURLY:  r = {1'b0, 1'b1, bnc_pkg::KIND_CURLY};
      bnc_pkg::CH_CLOSE_ANGLE:  r = {1'b0, 1'b1, bnc_pkg::KIND_ANGLE};
      default:                  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] open_char(logic [1:0] k);
    case (k)
      bnc_pkg::KIND_ROUND:  return bnc_pkg::CH_OPEN_ROUND;
      bnc_pkg::KIND_SQUARE: return bnc_pkg::CH_OPEN_SQUARE;
      bnc_pkg::KIND_CURLY:  return bnc_pkg::CH_OPEN_CURLY;
      default:              return bnc_pkg::CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(logic [1:0] k);
    case (k)
      bnc_pkg::KIND_ROUND:  return bnc_pkg::CH_CLOSE_ROUND;
      bnc_pkg::KIND_SQUARE: return bnc_pkg::CH_CLOSE_SQUARE;
      bnc_pkg::KIND_CURLY:  return bnc_pkg::CH_CLOSE_CURLY;
      default:              return bnc_pkg::CH_CLOSE_ANGLE;
    endcase
  endfunction

  // Walk the open stack top-down, saturating at the 64-bit ceiling
  function automatic logic [63:0] completion_of();
    logic [68:0] acc;
    int i;
    acc = '0;
    for (i = int'(stk_cnt) - 1; i >= 0; i--) begin
      acc = acc * mult_base + kind_stk[i] + 1;
      if (acc[68:64] != 0) return '1;
    end
    return acc[63:0];
  endfunction

  task automatic apply_reg(logic [bnc_pkg::CFG_A_W-1:0] idx,
                           logic [bnc_pkg::SCORE_W-1:0] val);
    case (idx)
      bnc_pkg::REG_ROUND:  close_score[bnc_pkg::KIND_ROUND]  = val;
      bnc_pkg::REG_SQUARE: close_score[bnc_pkg::KIND_SQUARE] = val;
      bnc_pkg::REG_CURLY:  close_score[bnc_pkg::KIND_CURLY]  = val;
      bnc_pkg::REG_ANGLE:  close_score[bnc_pkg::KIND_ANGLE]  = val;
      bnc_pkg::REG_BASE:   mult_base = val[3:0];
      default: ;
    endcase
  endtask

  // Advance the line state by one character; on a line end queue its report
  task automatic track_char(logic [7:0] c, logic last);
    char_class_t  cls;
    line_report_t r;
    logic [48:0]  sum;
    cls = classify(c);
    if (!ln_bad && !ln_ovf) begin
      if (cls.opener) begin
        if (stk_cnt < DEPTH) begin
          kind_stk[stk_cnt] = cls.kind;
          stk_cnt++;
        end else begin
          ln_ovf = 1'b1;
        end
      end else if (cls.closer) begin
        if (stk_cnt > 0 && kind_stk[stk_cnt-1] == cls.kind) begin
          stk_cnt--;
        end else begin
          ln_bad   = 1'b1;
          ln_score = close_score[cls.kind];
        end
      end
    end
    if (last) begin
      r.illegal = '0;
      r.compl   = '0;
      if (ln_bad) begin
        r.status  = bnc_pkg::LS_CORRUPTED;
        r.illegal = ln_score;
        sum = bad_total + ln_score;
        bad_total = sum[48] ? '1 : sum[47:0];
      end else if (ln_ovf) begin
        r.status = bnc_pkg::LS_OVERFLOW;
      end else if (stk_cnt == 0) begin
        r.status = bnc_pkg::LS_BALANCED;
      end else begin
        r.status = bnc_pkg::LS_INCOMPLETE;
        r.compl  = completion_of();
      end
      r.total = bad_total;
      report_q.insert(report_q.size(), r);
      stk_cnt  = 0;
      ln_bad   = 1'b0;
      ln_ovf   = 1'b0;
      ln_score = '0;
    end
  endtask

  // Monitor: check report beats, mirror register writes, track accepted chars
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("report beat with no line pending: status %0d", out_tuser);
          fail_cnt++;
        end else begin
          if (out_tuser !== report_q[0].status) begin
            $error("line_status: expected %0d, got %0d", report_q[0].status, out_tuser);
            fail_cnt++;
          end
          if (out_tdata[15:0] !== report_q[0].illegal) begin
            $error("illegal_score: expected %0d, got %0d",
                   report_q[0].illegal, out_tdata[15:0]);
            fail_cnt++;
          end
          if (out_tdata[63:16] !== report_q[0].total) begin
            $error("corruption_total: expected %0d, got %0d",
                   report_q[0].total, out_tdata[63:16]);
            fail_cnt++;
          end
          if (out_tdata[127:64] !== report_q[0].compl) begin
            $error("completion_score: expected %0d, got %0d",
                   report_q[0].compl, out_tdata[127:64]);
            fail_cnt++;
          end
          void'(report_q.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_addr, cfg_data);
      in_taken = in_tvalid && in_tready;
      if (in_taken) track_char(in_tdata, in_tlast);
    end
  end

  // Driver: release a taken beat, then idle, drain or offer the next one
  always @(negedge clk) begin
    if (drv_busy && in_taken) drv_busy = 1'b0;
    if (!drv_busy && rst_n) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (line_chars_q.size() != 0) begin
        if (line_chars_q[0].drain) begin
          if (report_q.size() == 0) void'(line_chars_q.pop_front());
        end else if ($urandom_range(0, 99) < idle_pct) begin
          tx_gap = $urandom_range(0, 7);
        end else begin
          tx_beat  = line_chars_q.pop_front();
          drv_busy = 1'b1;
        end
      end
    end
    in_tvalid <= drv_busy;
    in_tdata  <= tx_beat.ch;
    in_tlast  <= tx_beat.last;
  end

  // Receiver: random stall bursts, plus one long hold-off when armed
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      rx_stall = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic put(logic [7:0] c, logic last);
    line_chars_q.insert(line_chars_q.size(), beat_t'({c, last, 1'b0}));
  endtask

  // Build one line of the given shape and queue it; n returns its length
  task automatic add_line(line_shape_t shape, int unsigned span, output int unsigned n);
    logic [7:0]  chars[$];
    logic [1:0]  opens[$];
    logic [1:0]  k;
    logic [7:0]  c;
    char_class_t cls;
    int unsigned act;
    case (shape)
      LN_NOISE: begin
        repeat ($urandom_range(1, span)) begin
          chars.insert(chars.size(), 8'($urandom_range(0, 255)));
        end
      end
      LN_DEEP: begin
        repeat (span) chars.insert(chars.size(), open_char(2'($urandom_range(0, 3))));
        if (span > DEPTH) begin
          repeat ($urandom_range(1, 4)) begin
            chars.insert(chars.size(), 8'($urandom_range(0, 255)));
          end
        end
      end
      default: begin
        repeat ($urandom_range(1, span)) begin
          act = $urandom_range(0, 5);
          if (act >= 3 && opens.size() == 0) act = 0;
          case (act)
            0, 1: begin
              k = 2'($urandom_range(0, 3));
              opens.insert(opens.size(), k);
              chars.insert(chars.size(), open_char(k));
            end
            2: begin
              do begin
                c   = 8'($urandom_range(0, 255));
                cls = classify(c);
              end while (cls.opener || cls.closer);
              chars.insert(chars.size(), c);
            end
            default: begin
              k = opens[$];
              opens.delete(opens.size() - 1);
              chars.insert(chars.size(), close_char(k));
            end
          endcase
        end
        if (shape == LN_BAL) begin
          while (opens.size() != 0) begin
            k = opens[$];
            opens.delete(opens.size() - 1);
            chars.insert(chars.size(), close_char(k));
          end
        end else if (shape == LN_OPEN && opens.size() == 0) begin
          chars.insert(chars.size(), open_char(2'($urandom_range(0, 3))));
        end else if (shape == LN_BAD) begin
          // Wrong kind on top, or any closer on an empty stack
          if (opens.size() == 0) k = 2'($urandom_range(0, 3));
          else k = opens[$] + 2'($urandom_range(1, 3));
          chars.insert(chars.size(), close_char(k));
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 1) != 0) begin
              chars.insert(chars.size(), close_char(2'($urandom_range(0, 3))));
            end else begin
              chars.insert(chars.size(), 8'($urandom_range(0, 255)));
            end
          end
        end
      end
    endcase
    n = chars.size();
    foreach (chars[i]) put(chars[i], i == n - 1);
  endtask

  // Queue a random mix of balanced, incomplete, corrupted and noise lines, optionally with drain markers
  task automatic add_random(int unsigned beats, logic with_drain);
    int unsigned got;
    int unsigned n;
    int unsigned pick;
    int unsigned span;
    got = 0;
    while (got < beats) begin
      pick = $urandom_range(0, 99);
      span = ($urandom_range(0, 9) == 0) ? 30 : 10;
      if (pick < 35) add_line(LN_BAL, span, n);
      else if (pick < 60) add_line(LN_OPEN, span, n);
      else if (pick < 85) add_line(LN_BAD, span, n);
      else add_line(LN_NOISE, 6, n);
      got += n;
      if (with_drain && $urandom_range(0, 9) == 0) begin
        line_chars_q.insert(line_chars_q.size(), beat_t'({8'h00, 1'b0, 1'b1}));
      end
    end
  endtask

  task automatic write_reg(logic [bnc_pkg::CFG_A_W-1:0] idx,
                           logic [bnc_pkg::SCORE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] r, logic [15:0] s, logic [15:0] c, logic [15:0] a,
                          logic [3:0] b);
    write_reg(bnc_pkg::REG_ROUND, r);
    write_reg(bnc_pkg::REG_SQUARE, s);
    write_reg(bnc_pkg::REG_CURLY, c);
    write_reg(bnc_pkg::REG_ANGLE, a);
    // Upper data bits are don't-care for the base register
    write_reg(bnc_pkg::REG_BASE, {12'($urandom_range(0, 4095)), b});
  endtask

  // Hold until every queued beat is sent and every report has come back
  task automatic wait_idle();
    do @(negedge clk); while (line_chars_q.size() != 0 || drv_busy || report_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int unsigned n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines at reset register values
    idle_pct = 25;
    put(bnc_pkg::CH_OPEN_ROUND, 1'b0);
    put(bnc_pkg::CH_OPEN_SQUARE, 1'b0);
    put(bnc_pkg::CH_OPEN_CURLY, 1'b0);
    put(bnc_pkg::CH_OPEN_ANGLE, 1'b1);
    put(bnc_pkg::CH_CLOSE_ROUND, 1'b1);
    put(bnc_pkg::CH_OPEN_ROUND, 1'b0);
    put(bnc_pkg::CH_CLOSE_SQUARE, 1'b1);
    put(bnc_pkg::CH_OPEN_SQUARE, 1'b0);
    put(bnc_pkg::CH_CLOSE_CURLY, 1'b1);
    put(bnc_pkg::CH_OPEN_CURLY, 1'b0);
    put(bnc_pkg::CH_CLOSE_ANGLE, 1'b0);
    put(8'hFF, 1'b0);
    put(bnc_pkg::CH_CLOSE_SQUARE, 1'b1);
    put(bnc_pkg::CH_OPEN_ANGLE, 1'b0);
    put(bnc_pkg::CH_CLOSE_ANGLE, 1'b1);
    put(8'h00, 1'b1);
    put(bnc_pkg::CH_OPEN_ROUND, 1'b0);
    put(bnc_pkg::CH_OPEN_SQUARE, 1'b0);
    put(bnc_pkg::CH_OPEN_CURLY, 1'b0);
    put(bnc_pkg::CH_OPEN_ANGLE, 1'b0);
    put(bnc_pkg::CH_CLOSE_ANGLE, 1'b0);
    put(bnc_pkg::CH_CLOSE_CURLY, 1'b0);
    put(bnc_pkg::CH_CLOSE_SQUARE, 1'b0);
    put(bnc_pkg::CH_CLOSE_ROUND, 1'b1);
    wait_idle();

    // Minimum scores, base of one, no idling
    idle_pct = 0;
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 4'd1);
    add_line(LN_DEEP, DEPTH, n);
    add_random(60, 1'b0);
    wait_idle();

    // Maximum scores and base: saturating walks, full and overflowing stacks
    idle_pct = 30;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    add_line(LN_DEEP, 20, n);
    add_line(LN_DEEP, DEPTH, n);
    add_line(LN_DEEP, DEPTH + 6, n);
    add_random(70, 1'b0);
    hold_arm = 1'b1;
    wait_idle();

    // Base of zero, heavy idling, sender pauses for drains
    idle_pct = 50;
    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 4'd0);
    add_line(LN_DEEP, 12, n);
    add_random(60, 1'b1);
    wait_idle();

    // Random settings, no idling to the end
    idle_pct = 0;
    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             4'($urandom_range(1, 15)));
    add_random(80, 1'b0);
    wait_idle();

    if (fail_cnt == 0 && report_q.size() == 0) begin
      $display("bracket_nesting_checker: match");
    end else begin
      $display("bracket_nesting_checker: mismatch");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #1_000_000;
    $display("bracket_nesting_checker: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bnc_pkg.sv
rtl/bnc_ram.sv
rtl/bnc_compl.sv
rtl/bracket_nesting_checker.sv
bench/tb_bracket_nesting_checker.sv
